[rtl/core/hps_pkg.sv]
// hps_pkg: shared types and constants for the heading pd steering block
// no dependencies; imported by heading_pd_steering and heading_pd_steering_test
package hps_pkg;

	localparam int HEAD_W  = 17;   // heading and wrapped error width
	localparam int ERR_W   = 18;   // raw difference width before wrap
	localparam int GAIN_W  = 16;   // q8.8 gain width
	localparam int DRV_W   = 10;   // max_diff and ref_drive width
	localparam int CFG_W   = 16;   // widest config register
	localparam int IN_W    = 40;   // two headings packed, padded to bytes
	localparam int PROD_P_W = GAIN_W + 1 + HEAD_W;   // kp * err
	localparam int PROD_D_W = GAIN_W + 1 + ERR_W;    // kd * (err - prev)
	localparam int SUM_W   = PROD_D_W + 1;
	localparam int MAG_W   = SUM_W - 16;
	localparam int SAT_W   = 18;   // signed width covering any drive width up to 16

	// half and full turn in 1/256 degree
	localparam logic signed [ERR_W-1:0] HALF_TURN = 18'sd46080;
	localparam logic signed [ERR_W-1:0] FULL_TURN = 18'sd92160;

	// reset values of the config registers
	localparam logic [GAIN_W-1:0] KP_RESET  = 16'd358;
	localparam logic [GAIN_W-1:0] KD_RESET  = 16'd717;
	localparam logic [DRV_W-1:0]  MAXD_RESET = 10'd100;
	localparam logic [DRV_W-1:0]  REF_RESET = 10'd512;

	typedef enum logic [1:0] {
		REG_KP_GAIN   = 2'd0,
		REG_KD_GAIN   = 2'd1,
		REG_MAX_DIFF  = 2'd2,
		REG_REF_DRIVE = 2'd3
	} reg_idx_t;

endpackage

[rtl/core/heading_pd_steering.sv]
// heading_pd_steering: pd heading controller for a differential drive
// depends on hps_pkg (widths, turn constants, register indexes)
//
// channel  | dir | handshake         | payload, lowest bit first
// ---------+-----+-------------------+-------------------------------------------
// s_       | in  | s_tvalid/s_tready | tdata: measured_heading, target_heading
//          |     |                   | tuser: start_drive
// m_       | out | m_tvalid/m_tready | tdata: left_drive, right_drive, wrapped_error
//          |     |                   | tuser: drive_valid
// cfg_     | in  | cfg_we            | cfg_index selects register, cfg_wdata value
//
// one item per cycle sustained while m_tready stays high; the item is loaded
// into the wrap stage at the accepting edge, then into the multiply stage and
// then into the output stage, whose register offers its result on m_ until
// it is taken
// reset loads the default gains and limits, clears the previous error and
// empties the pipeline
// m_tready low holds the output register; bubbles in the earlier stages still
// fill, and s_tready drops only when every stage holds an item
module heading_pd_steering
	import hps_pkg::*;
#(
	parameter int DRIVE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // [16:0] measured_heading, [33:17] target_heading
	input  logic                 s_tuser,   // [0] start_drive
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [((2*DRIVE_BITS+HEAD_W+7)/8)*8-1:0] m_tdata,
	// m_tdata: left_drive, right_drive, wrapped_error (17 bit), zero pad
	output logic                 m_tuser    // [0] drive_valid
);

	localparam int OUT_W  = ((2*DRIVE_BITS + HEAD_W + 7) / 8) * 8;
	localparam int PAD_W  = OUT_W - (2*DRIVE_BITS + HEAD_W);
	localparam logic signed [SAT_W-1:0] DRIVE_MAX =
		SAT_W'((1 << DRIVE_BITS) - 1);

	// config registers
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] kd_q;
	logic [DRV_W-1:0]  maxd_q;
	logic [DRV_W-1:0]  ref_q;

	// previous error feeding the derivative term
	logic signed [HEAD_W-1:0] prev_q;

	// stage 1: wrapped error
	logic                     v_s1;
	logic signed [HEAD_W-1:0] err_s1;
	logic                     start_s1;

	// stage 2: products
	logic                       v_s2;
	logic signed [HEAD_W-1:0]   err_s2;
	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_D_W-1:0] prod_d_s2;

	// stage 3: result register
	logic                   v_s3;
	logic [DRIVE_BITS-1:0]  left_s3;
	logic [DRIVE_BITS-1:0]  right_s3;
	logic                   dvalid_s3;
	logic [HEAD_W-1:0]      werr_s3;

	// flow control
	logic load_s3, load_s2, load_s1;

	// wrap logic
	logic signed [ERR_W-1:0]  meas_x, targ_x, raw_err, wrap_err;
	// derivative difference
	logic signed [ERR_W-1:0]  prev_sel, diff;
	logic signed [PROD_P_W-1:0] prod_p;
	logic signed [PROD_D_W-1:0] prod_d;
	// correction and drives
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        abs_sum;
	logic [MAG_W-1:0]        mag;
	logic [DRV_W-1:0]        corr;
	logic signed [SAT_W-1:0] ref_x, corr_x, plus, minus, left_raw, right_raw;
	logic [DRIVE_BITS-1:0]   left_sat, right_sat;
	logic                    dvalid;

	// a stage takes a new item when it is empty or its content moves on
	assign load_s3  = !v_s3 || m_tready;
	assign load_s2  = !v_s2 || load_s3;
	assign load_s1  = !v_s1 || load_s2;
	assign s_tready = load_s1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			kd_q   <= KD_RESET;
			maxd_q <= MAXD_RESET;
			ref_q  <= REF_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KP_GAIN:   kp_q   <= cfg_wdata;
				REG_KD_GAIN:   kd_q   <= cfg_wdata;
				REG_MAX_DIFF:  maxd_q <= cfg_wdata[DRV_W-1:0];
				REG_REF_DRIVE: ref_q  <= cfg_wdata[DRV_W-1:0];
				default: ;
			endcase
		end
	end

	// error = target - measured, wrapped once by a full turn toward zero
	always_comb begin
		meas_x  = ERR_W'($signed(s_tdata[HEAD_W-1:0]));
		targ_x  = ERR_W'($signed(s_tdata[2*HEAD_W-1:HEAD_W]));
		raw_err = targ_x - meas_x;
		if (raw_err > HALF_TURN) begin
			wrap_err = raw_err - FULL_TURN;
		end else if (raw_err < -HALF_TURN) begin
			wrap_err = raw_err + FULL_TURN;
		end else begin
			wrap_err = raw_err;
		end
	end

	// start of a drive discards the stored error
	always_comb begin
		prev_sel = start_s1 ? '0 : ERR_W'(prev_q);
		diff     = ERR_W'(err_s1) - prev_sel;
		prod_p   = $signed({1'b0, kp_q}) * err_s1;
		prod_d   = $signed({1'b0, kd_q}) * diff;
	end

	// magnitude, clamp and drive saturation
	always_comb begin
		sum     = SUM_W'(prod_p_s2) + SUM_W'(prod_d_s2);
		abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		mag     = abs_sum[SUM_W-1:16];
		corr    = (mag > MAG_W'(maxd_q)) ? maxd_q : mag[DRV_W-1:0];
		dvalid  = (corr != '0) && (err_s2 != '0);
		ref_x   = SAT_W'(ref_q);
		corr_x  = SAT_W'(corr);
		plus    = ref_x + corr_x;
		minus   = ref_x - corr_x;
		// steer toward the target: negative error slows the left side
		left_raw  = err_s2[HEAD_W-1] ? minus : plus;
		right_raw = err_s2[HEAD_W-1] ? plus : minus;
		if (left_raw < 0) begin
			left_sat = '0;
		end else if (left_raw > DRIVE_MAX) begin
			left_sat = DRIVE_MAX[DRIVE_BITS-1:0];
		end else begin
			left_sat = left_raw[DRIVE_BITS-1:0];
		end
		if (right_raw < 0) begin
			right_sat = '0;
		end else if (right_raw > DRIVE_MAX) begin
			right_sat = DRIVE_MAX[DRIVE_BITS-1:0];
		end else begin
			right_sat = right_raw[DRIVE_BITS-1:0];
		end
	end

	// valid bits and stored error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			prev_q <= '0;
		end else begin
			if (load_s1) v_s1 <= s_tvalid;
			if (load_s2) v_s2 <= v_s1;
			if (load_s3) v_s3 <= v_s2;
			// error moves into the derivative history as it leaves stage 1
			if (v_s1 && load_s2) prev_q <= err_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			err_s1   <= wrap_err[HEAD_W-1:0];
			start_s1 <= s_tuser;
		end
		if (load_s2 && v_s1) begin
			err_s2    <= err_s1;
			prod_p_s2 <= prod_p;
			prod_d_s2 <= prod_d;
		end
		if (load_s3 && v_s2) begin
			left_s3   <= dvalid ? left_sat : '0;
			right_s3  <= dvalid ? right_sat : '0;
			dvalid_s3 <= dvalid;
			werr_s3   <= err_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{PAD_W{1'b0}}, werr_s3, right_s3, left_s3};
	assign m_tuser  = dvalid_s3;

	// a flagged result always has a nonzero error
	a_valid_err: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && dvalid_s3 |-> werr_s3 != '0)
		else $error("drive_valid with zero error");

	// a result without the flag carries zero drives
	a_idle_drives: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !dvalid_s3 |-> left_s3 == '0 && right_s3 == '0)
		else $error("nonzero drive on unflagged result");

	// wrapped error stays within half a turn
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $signed(werr_s3) <= 17'sd46080 && $signed(werr_s3) >= -17'sd46080)
		else $error("wrapped error out of range");

	// input blocked only when every stage holds an item and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && v_s3 && !m_tready)
		else $error("input blocked with room in the pipeline");

	// stored error changes only when an item leaves stage 1
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && load_s2) |=> $stable(prev_q))
		else $error("previous error changed without an item");

endmodule

[verif/heading_pd_steering_test.sv]
// heading_pd_steering_test: self-checking bench for the pd heading steering block
// depends on hps_pkg and heading_pd_steering; drives headings, predicts drives and checks them
module heading_pd_steering_test;
	import hps_pkg::*;

	localparam int DRV_BITS  = 10;
	localparam int RES_W     = ((2*DRV_BITS+HEAD_W+7)/8)*8;
	localparam int PIPE_LAT  = 3;      // pipeline depth: wrap, multiply and output stages
	localparam int STALL_MAX = 2000;   // cycles without any transfer before giving up
	localparam longint DRIVE_TOP = (1 << DRV_BITS) - 1;

	// one expected result, field by field
	typedef struct {
		logic [DRV_BITS-1:0]      left;
		logic [DRV_BITS-1:0]      right;
		logic                     valid;
		logic signed [HEAD_W-1:0] wrapped;
	} steer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;      // measured_heading, target_heading, zero pad
	logic s_tuser = 1'b0;               // start_drive
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_W-1:0] m_tdata;          // left_drive, right_drive, wrapped_error, zero pad
	logic m_tuser;                      // drive_valid

	// shadow of the block: config registers and the error of the last item
	logic [GAIN_W-1:0] kp_q = KP_RESET;
	logic [GAIN_W-1:0] kd_q = KD_RESET;
	logic [DRV_W-1:0] max_diff_q = MAXD_RESET;
	logic [DRV_W-1:0] ref_q = REF_RESET;
	longint last_error = 0;

	steer_result_t pending_drives[$];
	int fault_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	heading_pd_steering #(.DRIVE_BITS(DRV_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// wrap the heading error, form the pd correction and split it onto both motors;
	// the error of this item becomes the previous error of the next one
	function automatic steer_result_t predict_steering(logic signed [HEAD_W-1:0] meas,
			logic signed [HEAD_W-1:0] targ, logic start);
		steer_result_t r;
		longint err, base, sum, mag, corr, lo, hi;
		err = longint'(targ) - longint'(meas);
		// one wrap by a full turn; exactly half a turn stays as it is
		if (err > longint'(HALF_TURN)) begin
			err = err - longint'(FULL_TURN);
		end else if (err < -longint'(HALF_TURN)) begin
			err = err + longint'(FULL_TURN);
		end
		base = start ? 0 : last_error;
		sum = longint'(kp_q) * err + longint'(kd_q) * (err - base);
		mag = (sum < 0 ? -sum : sum) >> 16;
		corr = (mag > longint'(max_diff_q)) ? longint'(max_diff_q) : mag;
		r.left = '0;
		r.right = '0;
		// zero error never drives, even with a derivative kick
		r.valid = (corr != 0) && (err != 0);
		if (r.valid) begin
			lo = longint'(ref_q) - corr;
			hi = longint'(ref_q) + corr;
			if (lo < 0) lo = 0;
			if (hi > DRIVE_TOP) hi = DRIVE_TOP;
			// steer toward the target: negative error speeds up the right motor
			if (err < 0) begin
				r.left = lo[DRV_BITS-1:0];
				r.right = hi[DRV_BITS-1:0];
			end else begin
				r.left = hi[DRV_BITS-1:0];
				r.right = lo[DRV_BITS-1:0];
			end
		end
		r.wrapped = err[HEAD_W-1:0];
		last_error = err;
		return r;
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// send one heading item; valid stays high afterwards so back-to-back items
	// never lower and raise it in the same step
	task automatic send_heading(input logic signed [HEAD_W-1:0] meas,
			input logic signed [HEAD_W-1:0] targ, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-2*HEAD_W){1'b0}}, targ, meas};
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		pending_drives.push_back(predict_steering(meas, targ, start));
	endtask

	// stop sending, let every pending result come out, then let the pipe go quiet
	task automatic settle_pipeline;
		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// register write takes effect at the edge; the shadow follows it
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_KP_GAIN: begin
				kp_q = val;
			end
			REG_KD_GAIN: begin
				kd_q = val;
			end
			REG_MAX_DIFF: begin
				max_diff_q = val[DRV_W-1:0];
			end
			REG_REF_DRIVE: begin
				ref_q = val[DRV_W-1:0];
			end
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// default gains: wrap edges, zero error, start flag, out of range headings
	task automatic test_reset_defaults;
		send_heading(17'sd0, 17'sd0, 1'b1);              // nothing to correct
		send_heading(17'sd0, 17'sd46080, 1'b0);          // half turn, no wrap
		send_heading(17'sd0, -17'sd46080, 1'b0);         // negative half turn
		send_heading(17'sd0, 17'sd46081, 1'b0);          // just past half turn, wraps
		send_heading(17'sd46080, -17'sd46080, 1'b0);     // full turn wraps to zero error
		send_heading(-17'sd46080, 17'sd46080, 1'b1);
		send_heading(-17'sd65536, 17'sd65535, 1'b0);     // largest patterns, positive
		send_heading(17'sd65535, -17'sd65536, 1'b0);     // largest patterns, negative
		send_heading(17'sd100, 17'sd100, 1'b0);          // zero error after a big one
		send_heading(17'sd0, 17'sd10, 1'b1);             // too small to drive
		send_heading(17'sd0, 17'sd10, 1'b0);
		send_heading(17'sd0, 17'sd200, 1'b0);            // small valid correction
		send_heading(17'sd0, -17'sd200, 1'b1);
		send_heading(-17'sd46080, -17'sd46080, 1'b0);
		send_heading(17'sd46080, 17'sd0, 1'b0);
		send_heading(17'sd0, -17'sd1, 1'b0);
		settle_pipeline();
	endtask

	// gain and limit extremes, masking of wide writes and drive saturation
	task automatic test_gain_extremes;
		write_reg(REG_KP_GAIN, 16'd0);
		write_reg(REG_KD_GAIN, 16'd0);
		write_reg(REG_MAX_DIFF, 16'd1023);
		write_reg(REG_REF_DRIVE, 16'hFFFF);              // upper bits dropped
		send_heading(17'sd0, 17'sd1000, 1'b1);           // no gain, never valid
		send_heading(17'sd0, -17'sd1000, 1'b0);
		settle_pipeline();
		write_reg(REG_KP_GAIN, 16'hFFFF);
		write_reg(REG_KD_GAIN, 16'hFFFF);
		send_heading(17'sd0, 17'sd46080, 1'b1);          // clamp and saturate high side
		send_heading(17'sd0, -17'sd46080, 1'b0);
		settle_pipeline();
		write_reg(REG_REF_DRIVE, 16'd0);
		send_heading(17'sd0, 17'sd30000, 1'b1);          // low side saturates at zero
		settle_pipeline();
		write_reg(REG_MAX_DIFF, 16'hFC00);               // masks to a zero limit
		send_heading(17'sd0, 17'sd20000, 1'b0);
		settle_pipeline();
		write_reg(REG_KP_GAIN, 16'd256);
		write_reg(REG_KD_GAIN, 16'd0);
		write_reg(REG_MAX_DIFF, 16'd100);
		write_reg(REG_REF_DRIVE, 16'd512);
		send_heading(17'sd0, 17'sd12800, 1'b1);          // plain proportional, unclamped
		send_heading(17'sd1000, 17'sd0, 1'b0);
		settle_pipeline();
	endtask

	// batches of drive runs and noise items, new random config registers between batches
	task automatic test_random_steering(input int total, input int s_idle, input int r_idle);
		int sent, batch, done_in_batch, len, i, meas, targ, noise;
		logic [CFG_W-1:0] val;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		sent = 0;
		while (sent < total) begin
			for (i = 0; i < 4; i++) begin
				case ($urandom_range(3))
					0: val = '0;
					1: val = 16'hFFFF;
					2: val = CFG_W'($urandom_range(1023));
					default: val = CFG_W'($urandom_range(16'hFFFF));
				endcase
				write_reg(reg_idx_t'(i), val);
			end
			batch = $urandom_range(40, 120);
			done_in_batch = 0;
			while (done_in_batch < batch) begin
				if ($urandom_range(99) < 75) begin
					// a drive run: a start in most runs, then the heading closes in on the target
					targ = int'($urandom_range(92160)) - 46080;
					meas = int'($urandom_range(92160)) - 46080;
					len = $urandom_range(2, 10);
					for (i = 0; i < len; i++) begin
						send_heading(meas[HEAD_W-1:0], targ[HEAD_W-1:0],
							(i == 0) && ($urandom_range(9) != 0));
						noise = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(8)) - 4;
						meas = meas + (targ - meas) / 2 + noise;
					end
					done_in_batch += len;
				end else begin
					// any pattern at all, including headings out of range
					send_heading(HEAD_W'($urandom_range(17'h1FFFF)),
						HEAD_W'($urandom_range(17'h1FFFF)), 1'($urandom_range(1)));
					done_in_batch++;
				end
			end
			sent += done_in_batch;
			settle_pipeline();
		end
	endtask

	// result check, and the receiver's own stalls
	always @(posedge clk) begin : check_result
		steer_result_t want;
		logic [DRV_BITS-1:0] got_left, got_right;
		logic signed [HEAD_W-1:0] got_err;
		got_left = m_tdata[DRV_BITS-1:0];
		got_right = m_tdata[2*DRV_BITS-1:DRV_BITS];
		got_err = m_tdata[2*DRV_BITS+HEAD_W-1:2*DRV_BITS];
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				log_fault($sformatf("result with nothing pending: left %0d right %0d err %0d",
					got_left, got_right, got_err));
			end else begin
				want = pending_drives.pop_front();
				if (got_left !== want.left || got_right !== want.right ||
						m_tuser !== want.valid || got_err !== want.wrapped) begin
					log_fault($sformatf({"expected left %0d right %0d valid %0b err %0d, ",
						"got left %0d right %0d valid %0b err %0d"},
						want.left, want.right, want.valid, want.wrapped,
						got_left, got_right, m_tuser, got_err));
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 54;
		test_reset_defaults();
		test_gain_extremes();
		test_random_steering(650, 35, 54);
		test_random_steering(650, 54, 35);
		test_random_steering(650, 0, 0);
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/hps_pkg.sv
rtl/core/heading_pd_steering.sv
verif/heading_pd_steering_test.sv
